[rtl/sorted_table_floor_ceil_search_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table floor and ceil search block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_FLOOR_CEIL_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_FLOOR_CEIL_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STFCS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("stfcs: implication check failed");
`define STFCS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("stfcs: next-cycle check failed");
`else
`define STFCS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define STFCS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

[rtl/stfcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfcs_pkg
// Shared constants and types of the sorted table floor and ceil search block.
// ----------------------------------------------------------------------------
package stfcs_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // word index of the entry_count register
  localparam logic REG_ENTRY_COUNT = 1'b0;

  localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PROBE  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

[rtl/sorted_table_floor_ceil_search_top.sv]
`timescale 1ns / 1ps
`include "sorted_table_floor_ceil_search_top_defines.svh"
// ----------------------------------------------------------------------------
// sorted_table_floor_ceil_search_top
// Sorted table with binary-search floor and ceil lookup.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser selects write (0) or query (1). A write stores
//   tdata value at tdata entry_index and returns nothing; indexes at or above
//   MAX_ENTRIES are dropped. A query searches the first entry_count entries
//   (APB register 0, saturated at MAX_ENTRIES) and returns one m_axis item
//   with floor and ceil, each -1 with a cleared flag if absent.
//   A query runs two binary searches on one RAM read port, one probe a cycle:
//   it is accepted in idle, probes the floor pass and then the ceil pass, and
//   ends in finish. The next item is accepted the cycle after finish.
//   s_axis_tready is low while a query is in flight. If m_axis stalls, a
//   finished result waits in the output register and a second query waits in
//   its finish cycle until the register frees up.
//   Reset clears entry_count and the control state; table contents are kept
//   and are undefined until written. No clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_table_floor_ceil_search_top
  import stfcs_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // item in: tuser = func
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata [9:0] entry_index, [41:10] value, [47:42] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser [0] func
  input  logic                   s_axis_tuser,
  // result out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata [31:0] floor_value, [32] floor_found, [64:33] ceil_value,
  //       [65] ceil_found, [71:66] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = CW + 1;

  state_t state;

  logic [COUNT_W-1:0] entry_count;

  func_t                      in_func;
  logic [INDEX_W-1:0]         in_index;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       in_accept;
  logic                       q_accept;
  logic                       ram_we;

  logic [CW-1:0]              n_cfg;
  logic [CW-1:0]              n_reg;
  logic [SW-1:0]              nm1_cfg;
  logic [SW-1:0]              nm1_reg;

  logic signed [VALUE_W-1:0]  key;
  logic signed [SW-1:0]       lo;
  logic signed [SW-1:0]       hi;
  logic [AW-1:0]              mid_reg;
  logic                       is_ceil;

  logic [AW-1:0]              raddr;
  logic [VALUE_W-1:0]         rdata;
  logic signed [VALUE_W-1:0]  ent;
  logic signed [SW-1:0]       mid_s;
  logic                       go_left;
  logic signed [SW-1:0]       lo_n;
  logic signed [SW-1:0]       hi_n;
  logic                       cont;
  logic [SW-1:0]              nsum;

  logic signed [VALUE_W-1:0]  floor_value;
  logic                       floor_found;
  logic signed [VALUE_W-1:0]  ceil_value;
  logic                       ceil_found;

  logic signed [VALUE_W-1:0]  out_floor_value;
  logic                       out_floor_found;
  logic signed [VALUE_W-1:0]  out_ceil_value;
  logic                       out_ceil_found;
  logic                       out_load;
  logic                       cfg_we;

  // --------------------------------------------------------------------------
  // Input decode and configuration port
  // --------------------------------------------------------------------------
  assign in_func  = func_t'(s_axis_tuser);
  assign in_index = s_axis_tdata[INDEX_W-1:0];
  assign in_value = $signed(s_axis_tdata[INDEX_W +: VALUE_W]);

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign q_accept      = in_accept && (in_func == FUNC_QUERY);
  assign ram_we        = in_accept && (in_func == FUNC_WRITE) &&
                         (32'(in_index) < 32'(MAX_ENTRIES));

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) ?
                  APB_DATA_W'(entry_count) : '0;

  // saturate the active count at capacity
  assign n_cfg   = (32'(entry_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                          : CW'(entry_count);
  assign nm1_cfg = SW'(n_cfg) - SW'(1);
  assign nm1_reg = SW'(n_reg) - SW'(1);

  // --------------------------------------------------------------------------
  // Shared probe unit: one compare and one lo/hi update per cycle
  // --------------------------------------------------------------------------
  assign ent     = $signed(rdata);
  assign mid_s   = $signed(SW'(mid_reg));
  assign go_left = is_ceil ? (key <= ent) : (key < ent);
  assign lo_n    = go_left ? lo : (mid_s + SW'(1));
  assign hi_n    = go_left ? (mid_s - SW'(1)) : hi;
  assign cont    = (lo_n <= hi_n);
  assign nsum    = $unsigned(lo_n) + $unsigned(hi_n);

  always_comb begin
    raddr = mid_reg;
    if (state == S_IDLE) begin
      raddr = nm1_cfg[AW:1];
    end else if (state == S_PROBE) begin
      raddr = cont ? nsum[AW:1] : nm1_reg[AW:1];
    end
  end

  stfcs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_index)),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_load = (state == S_FINISH) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      entry_count   <= '0;
    end else begin
      if (cfg_we) begin
        entry_count <= pwdata[COUNT_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_accept) begin
            state <= (n_cfg == '0) ? S_FINISH : S_PROBE;
          end
        end
        S_PROBE: begin
          if (!cont && is_ceil) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    mid_reg <= raddr;
    if (q_accept) begin
      key         <= in_value;
      n_reg       <= n_cfg;
      lo          <= '0;
      hi          <= $signed(nm1_cfg);
      is_ceil     <= 1'b0;
      floor_value <= NONE_VALUE;
      floor_found <= 1'b0;
      ceil_value  <= NONE_VALUE;
      ceil_found  <= 1'b0;
    end else if (state == S_PROBE) begin
      // capture the entry that the final index will point at
      if (!is_ceil && !go_left) begin
        floor_value <= ent;
        floor_found <= 1'b1;
      end
      if (is_ceil && go_left) begin
        ceil_value <= ent;
        ceil_found <= 1'b1;
      end
      if (cont) begin
        lo <= lo_n;
        hi <= hi_n;
      end else begin
        // restart over the full range for the ceil pass
        lo      <= '0;
        hi      <= $signed(nm1_reg);
        is_ceil <= 1'b1;
      end
    end
    if (out_load) begin
      out_floor_value <= floor_value;
      out_floor_found <= floor_found;
      out_ceil_value  <= ceil_value;
      out_ceil_found  <= ceil_found;
    end
  end

  assign m_axis_tdata = {6'b0, out_ceil_found, out_ceil_value,
                         out_floor_found, out_floor_value};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `STFCS_ASSERT_IMP(a_probe_in_range, clk, rst, state == S_PROBE,
                    32'(mid_reg) < 32'(n_reg))
  `STFCS_ASSERT_IMP(a_floor_none, clk, rst, m_axis_tvalid && !out_floor_found,
                    out_floor_value == NONE_VALUE)
  `STFCS_ASSERT_IMP(a_ceil_none, clk, rst, m_axis_tvalid && !out_ceil_found,
                    out_ceil_value == NONE_VALUE)
  `STFCS_ASSERT_NXT(a_query_busy, clk, rst, q_accept, !s_axis_tready)

endmodule

[rtl/stfcs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stfcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
